// ----- rtl/core/rau_pkg.sv -----
// Shared definitions for the rational arithmetic unit.
// Operation codes, the shared unit command type and default widths.
// No dependencies; compile first.
package rau_pkg;

	localparam int RAU_OPERAND_WIDTH = 16;
	localparam int OP_WIDTH = 3;

	typedef logic [OP_WIDTH-1:0] op_code_t;

	localparam op_code_t OP_ADD = 3'd0;
	localparam op_code_t OP_SUB = 3'd1;
	localparam op_code_t OP_MUL = 3'd2;
	localparam op_code_t OP_DIV = 3'd3;
	localparam op_code_t OP_CMP = 3'd4;

	typedef enum logic [1:0] {
		ALU_GCD,
		ALU_DIV,
		ALU_MUL
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_ctl_t;

endpackage

// ----- rtl/core/rau_cmd_if.sv -----
// Input channel of the rational arithmetic unit: operation and two raw fractions.
// Depends on rau_pkg.
interface rau_cmd_if #(
	parameter int OPERAND_WIDTH = rau_pkg::RAU_OPERAND_WIDTH
);
	import rau_pkg::*;

	logic                            valid;
	logic                            ready;
	op_code_t                        operation;
	logic signed [OPERAND_WIDTH-1:0] a_num;
	logic signed [OPERAND_WIDTH-1:0] a_den;
	logic signed [OPERAND_WIDTH-1:0] b_num;
	logic signed [OPERAND_WIDTH-1:0] b_den;

	modport source (
		output valid, operation, a_num, a_den, b_num, b_den,
		input  ready
	);

	modport sink (
		input  valid, operation, a_num, a_den, b_num, b_den,
		output ready
	);

endinterface

// ----- rtl/core/rau_rsp_if.sv -----
// Output channel of the rational arithmetic unit: reduced fraction and equal flag.
// Depends on rau_pkg for the default width.
interface rau_rsp_if #(
	parameter int OPERAND_WIDTH = rau_pkg::RAU_OPERAND_WIDTH
);
	logic                              valid;
	logic                              ready;
	logic signed [2*OPERAND_WIDTH:0]   result_num;
	logic        [2*OPERAND_WIDTH-2:0] result_den;
	logic                              equal;

	modport source (
		output valid, result_num, result_den, equal,
		input  ready
	);

	modport sink (
		input  valid, result_num, result_den, equal,
		output ready
	);

endinterface

// ----- rtl/core/rational_arithmetic_unit.sv -----
// Rational arithmetic unit top level: sequencer around the shared rau_alu.
// Depends on rau_pkg, rau_cmd_if, rau_rsp_if and rau_alu.
//
//  channel  dir  payload                               handshake
//  cmd      in   operation, a_num, a_den, b_num, b_den  valid/ready
//  rsp      out  result_num, result_den, equal         valid/ready
//
// One item at a time. Each nonzero operand is reduced by a binary GCD and two W-bit
// divisions; a nonzero result, but for a compare, by a GCD and two (2W+1)-bit
// divisions; three multiplies sit between, all on the one shared unit.
// cmd.ready is high only while idle; a finished result waits in the output
// register while the next item is taken. Reset clears control state only.
module rational_arithmetic_unit #(
	parameter int OPERAND_WIDTH = rau_pkg::RAU_OPERAND_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	rau_cmd_if.sink   cmd,
	rau_rsp_if.source rsp
);
	import rau_pkg::*;

	localparam int W  = OPERAND_WIDTH;
	localparam int N  = 2 * W + 1;
	localparam int LW = $clog2(N + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_GCD,
		S_DIVN,
		S_DIVD,
		S_STORE,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_COMB,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		SEL_A,
		SEL_B,
		SEL_R
	} sel_t;

	state_t          state_q;
	sel_t            sel_q;
	logic            wait_q;
	op_code_t        op_q;
	logic [W-1:0]    na_q, da_q, nb_q, db_q;
	logic            a_neg_q, b_neg_q, r_neg_q;
	logic [N-1:0]    fn_q, fd_q, g_q;
	logic [2*W-1:0]  p1_q, p2_q, p3_q;
	logic            eq_q;
	logic            rsp_valid_q;
	logic [N-1:0]    out_num_q;
	logic [2*W-2:0]  out_den_q;
	logic            out_eq_q;

	alu_ctl_t        alu_ctl;
	logic [N-1:0]    alu_x, alu_y, alu_res;
	logic [LW-1:0]   alu_len;
	logic            alu_done;

	logic            sb_eff;
	logic            add_neg;
	logic [N-1:0]    add_mag;

	function automatic logic [W-1:0] mag_of(logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	rau_alu #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.x      (alu_x),
		.y      (alu_y),
		.len    (alu_len),
		.done   (alu_done),
		.res    (alu_res)
	);

	// command to the shared unit, issued once on entry to each step
	always_comb begin
		alu_ctl.start = 1'b0;
		alu_ctl.op    = ALU_GCD;
		alu_x         = '0;
		alu_y         = '0;
		alu_len       = (sel_q == SEL_R) ? LW'(N) : LW'(W);
		case (state_q)
			S_GCD: begin
				alu_ctl.start = !wait_q;
				alu_x         = fn_q;
				alu_y         = fd_q;
			end
			S_DIVN: begin
				alu_ctl.start = !wait_q;
				alu_ctl.op    = ALU_DIV;
				alu_x         = fn_q;
				alu_y         = g_q;
			end
			S_DIVD: begin
				alu_ctl.start = !wait_q;
				alu_ctl.op    = ALU_DIV;
				alu_x         = fd_q;
				alu_y         = g_q;
			end
			S_MUL1: begin
				alu_ctl.start = !wait_q;
				alu_ctl.op    = ALU_MUL;
				alu_x         = N'(na_q);
				alu_y         = (op_q == OP_MUL) ? N'(nb_q) : N'(db_q);
			end
			S_MUL2: begin
				alu_ctl.start = !wait_q;
				alu_ctl.op    = ALU_MUL;
				alu_x         = N'(da_q);
				alu_y         = N'(nb_q);
			end
			S_MUL3: begin
				alu_ctl.start = !wait_q;
				alu_ctl.op    = ALU_MUL;
				alu_x         = N'(da_q);
				alu_y         = N'(db_q);
			end
			default: ;
		endcase
	end

	// sign-magnitude sum of the cross products
	always_comb begin
		sb_eff = b_neg_q ^ (op_q == OP_SUB);
		if (a_neg_q == sb_eff) begin
			add_neg = a_neg_q;
			add_mag = N'(p1_q) + N'(p2_q);
		end else if (p1_q >= p2_q) begin
			add_neg = a_neg_q;
			add_mag = N'(p1_q - p2_q);
		end else begin
			add_neg = sb_eff;
			add_mag = N'(p2_q - p1_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_q       <= SEL_A;
			wait_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						op_q    <= cmd.operation;
						na_q    <= mag_of(cmd.a_num);
						da_q    <= mag_of(cmd.a_den);
						nb_q    <= mag_of(cmd.b_num);
						db_q    <= mag_of(cmd.b_den);
						a_neg_q <= cmd.a_num[W-1] ^ cmd.a_den[W-1];
						b_neg_q <= cmd.b_num[W-1] ^ cmd.b_den[W-1];
						fn_q    <= N'(mag_of(cmd.a_num));
						fd_q    <= N'(mag_of(cmd.a_den));
						eq_q    <= 1'b0;
						sel_q   <= SEL_A;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					// a zero on either side collapses to 0/1
					if (fn_q == '0 || fd_q == '0) begin
						fn_q <= '0;
						fd_q <= N'(1);
						case (sel_q)
							SEL_A:   a_neg_q <= 1'b0;
							SEL_B:   b_neg_q <= 1'b0;
							default: r_neg_q <= 1'b0;
						endcase
						state_q <= S_STORE;
					end else begin
						state_q <= S_GCD;
					end
				end
				S_GCD: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (alu_done) begin
						wait_q  <= 1'b0;
						g_q     <= alu_res;
						state_q <= S_DIVN;
					end
				end
				S_DIVN: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (alu_done) begin
						wait_q  <= 1'b0;
						fn_q    <= alu_res;
						state_q <= S_DIVD;
					end
				end
				S_DIVD: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (alu_done) begin
						wait_q  <= 1'b0;
						fd_q    <= alu_res;
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					case (sel_q)
						SEL_A: begin
							na_q    <= fn_q[W-1:0];
							da_q    <= fd_q[W-1:0];
							fn_q    <= N'(nb_q);
							fd_q    <= N'(db_q);
							sel_q   <= SEL_B;
							state_q <= S_LOAD;
						end
						SEL_B: begin
							nb_q    <= fn_q[W-1:0];
							db_q    <= fd_q[W-1:0];
							state_q <= S_MUL1;
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_MUL1: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (alu_done) begin
						wait_q  <= 1'b0;
						p1_q    <= alu_res[2*W-1:0];
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (alu_done) begin
						wait_q  <= 1'b0;
						p2_q    <= alu_res[2*W-1:0];
						state_q <= S_MUL3;
					end
				end
				S_MUL3: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (alu_done) begin
						wait_q  <= 1'b0;
						p3_q    <= alu_res[2*W-1:0];
						state_q <= S_COMB;
					end
				end
				S_COMB: begin
					sel_q <= SEL_R;
					case (op_q)
						OP_ADD, OP_SUB: begin
							r_neg_q <= add_neg;
							fn_q    <= add_mag;
							fd_q    <= N'(p3_q);
							state_q <= S_LOAD;
						end
						OP_MUL: begin
							r_neg_q <= a_neg_q ^ b_neg_q;
							fn_q    <= N'(p1_q);
							fd_q    <= N'(p3_q);
							state_q <= S_LOAD;
						end
						OP_DIV: begin
							r_neg_q <= a_neg_q ^ b_neg_q;
							fn_q    <= N'(p1_q);
							fd_q    <= N'(p2_q);
							state_q <= S_LOAD;
						end
						OP_CMP: begin
							eq_q    <= (a_neg_q == b_neg_q) && (p1_q == p2_q);
							r_neg_q <= 1'b0;
							fn_q    <= '0;
							fd_q    <= N'(1);
							state_q <= S_FIN;
						end
						default: begin
							r_neg_q <= 1'b0;
							fn_q    <= '0;
							fd_q    <= N'(1);
							state_q <= S_FIN;
						end
					endcase
				end
				S_FIN: begin
					// hold until the output register is free
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						out_num_q   <= r_neg_q ? (N'(0) - fn_q) : fn_q;
						out_den_q   <= fd_q[2*W-2:0];
						out_eq_q    <= eq_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd.ready      = (state_q == S_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.result_num = out_num_q;
	assign rsp.result_den = out_den_q;
	assign rsp.equal      = out_eq_q;

endmodule

// ----- rtl/core/rau_alu.sv -----
// Shared iterative unit: binary GCD, restoring division one bit per cycle,
// and a registered magnitude multiply. Depends on rau_pkg.
module rau_alu #(
	parameter int OPERAND_WIDTH = rau_pkg::RAU_OPERAND_WIDTH
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  rau_pkg::alu_ctl_t                       ctl,
	input  logic [2*OPERAND_WIDTH:0]                x,
	input  logic [2*OPERAND_WIDTH:0]                y,
	input  logic [$clog2(2*OPERAND_WIDTH+2)-1:0]    len,
	output logic                                    done,
	output logic [2*OPERAND_WIDTH:0]                res
);
	import rau_pkg::*;

	localparam int W  = OPERAND_WIDTH;
	localparam int N  = 2 * W + 1;
	localparam int LW = $clog2(N + 1);
	localparam int IW = $clog2(N);

	typedef enum logic [1:0] {
		A_IDLE,
		A_GCD,
		A_DIV
	} alu_state_t;

	alu_state_t      state_q;
	logic [N-1:0]    u_q;
	logic [N-1:0]    v_q;
	logic [LW-1:0]   k_q;
	logic [LW-1:0]   cnt_q;
	logic [N-1:0]    rem_q;
	logic [N-1:0]    quo_q;
	logic            done_q;
	logic [N-1:0]    res_q;

	logic [2*W-1:0]  prod;
	logic [IW-1:0]   bit_idx;
	logic [N:0]      trial;
	logic            fits;
	logic [N-1:0]    quo_next;

	assign prod = x[W-1:0] * y[W-1:0];

	always_comb begin
		bit_idx  = IW'(cnt_q - 1'b1);
		trial    = {rem_q, u_q[bit_idx]};
		fits     = trial >= {1'b0, v_q};
		quo_next = {quo_q[N-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				A_IDLE: begin
					done_q <= ctl.start && (ctl.op == ALU_MUL);
					if (ctl.start) begin
						case (ctl.op)
							ALU_GCD: begin
								u_q     <= x;
								v_q     <= y;
								k_q     <= '0;
								state_q <= A_GCD;
							end
							ALU_DIV: begin
								u_q     <= x;
								v_q     <= y;
								cnt_q   <= len;
								rem_q   <= '0;
								quo_q   <= '0;
								state_q <= A_DIV;
							end
							ALU_MUL: begin
								res_q  <= N'(prod);
							end
							default: ;
						endcase
					end
				end
				A_GCD: begin
					done_q <= (u_q == v_q);
					// strip common twos, then subtract odd from odd
					if (u_q == v_q) begin
						res_q   <= u_q << k_q;
						state_q <= A_IDLE;
					end else if (!u_q[0] && !v_q[0]) begin
						u_q <= u_q >> 1;
						v_q <= v_q >> 1;
						k_q <= k_q + 1'b1;
					end else if (!u_q[0]) begin
						u_q <= u_q >> 1;
					end else if (!v_q[0]) begin
						v_q <= v_q >> 1;
					end else if (u_q > v_q) begin
						u_q <= (u_q - v_q) >> 1;
					end else begin
						v_q <= (v_q - u_q) >> 1;
					end
				end
				A_DIV: begin
					done_q <= (cnt_q == LW'(1));
					if (fits) begin
						rem_q <= N'(trial - {1'b0, v_q});
					end else begin
						rem_q <= trial[N-1:0];
					end
					quo_q <= quo_next;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == LW'(1)) begin
						res_q   <= quo_next;
						state_q <= A_IDLE;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
